[design/a2m_pkg.sv]
// Shared types, result codes and the Morse pattern table for the ASCII-to-Morse ring buffer.
package a2m_pkg;

	localparam int BUF_DEPTH_DEF = 32;
	localparam int PAT_BYTES     = 7;
	localparam int PAT_W         = 8 * PAT_BYTES;

	typedef enum logic [2:0] {
		ST_ACCEPT  = 3'd0,
		ST_SKIP    = 3'd1,
		ST_NOROOM  = 3'd2,
		ST_BYTE    = 3'd3,
		ST_EMPTY   = 3'd4
	} status_t;

	typedef enum logic {
		KIND_WRITE = 1'b0,
		KIND_READ  = 1'b1
	} kind_t;

	// text holds the pattern left-justified: first byte in the top byte
	typedef struct packed {
		logic             ok;
		logic [2:0]       len;
		logic [PAT_W-1:0] text;
	} pat_t;

	function automatic pat_t mk(input logic [2:0] n, input logic [PAT_W-1:0] s);
		pat_t r;
		r.ok   = 1'b1;
		r.len  = n;
		r.text = s << (8 * (PAT_BYTES - int'(n)));
		return r;
	endfunction

	function automatic pat_t pat_lookup(input logic [7:0] ch);
		pat_t       r;
		logic [7:0] c;
		r = '0;
		// fold lower case onto upper case
		c = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
		case (c)
			"0": r = mk(3'd6, "----- ");
			"1": r = mk(3'd6, ".---- ");
			"2": r = mk(3'd6, "..--- ");
			"3": r = mk(3'd6, "...-- ");
			"4": r = mk(3'd6, "....- ");
			"5": r = mk(3'd6, "..... ");
			"6": r = mk(3'd6, "-.... ");
			"7": r = mk(3'd6, "--... ");
			"8": r = mk(3'd6, "---.. ");
			"9": r = mk(3'd6, "----. ");
			"A": r = mk(3'd3, ".- ");
			"B": r = mk(3'd5, "-... ");
			"C": r = mk(3'd5, "-.-. ");
			"D": r = mk(3'd4, "-.. ");
			"E": r = mk(3'd2, ". ");
			"F": r = mk(3'd5, "..-. ");
			"G": r = mk(3'd4, "--. ");
			"H": r = mk(3'd5, ".... ");
			"I": r = mk(3'd3, ".. ");
			"J": r = mk(3'd5, ".--- ");
			"K": r = mk(3'd4, "-.- ");
			"L": r = mk(3'd5, ".-.. ");
			"M": r = mk(3'd3, "-- ");
			"N": r = mk(3'd3, "-. ");
			"O": r = mk(3'd4, "--- ");
			"P": r = mk(3'd5, ".--. ");
			"Q": r = mk(3'd5, "--.- ");
			"R": r = mk(3'd4, ".-. ");
			"S": r = mk(3'd4, "... ");
			"T": r = mk(3'd2, "- ");
			"U": r = mk(3'd4, "..- ");
			"V": r = mk(3'd5, "...- ");
			"W": r = mk(3'd4, ".-- ");
			"X": r = mk(3'd5, "-..- ");
			"Y": r = mk(3'd5, "-.-- ");
			"Z": r = mk(3'd5, "--.. ");
			"\"": r = mk(3'd7, ".-..-. ");
			"'": r = mk(3'd7, ".----. ");
			"(": r = mk(3'd6, "-.--. ");
			")": r = mk(3'd7, "-.--.- ");
			"*": r = mk(3'd5, "-..- ");
			"+": r = mk(3'd6, ".-.-. ");
			",": r = mk(3'd7, "--..-- ");
			"-": r = mk(3'd7, "-....- ");
			".": r = mk(3'd7, ".-.-.- ");
			"/": r = mk(3'd6, "-..-. ");
			":": r = mk(3'd7, "---... ");
			"=": r = mk(3'd6, "-...- ");
			"?": r = mk(3'd7, "..--.. ");
			"@": r = mk(3'd7, ".--.-. ");
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

[design/a2m_ring.sv]
// Byte ring storage: one write port and one registered read port.
module a2m_ring #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// hold the last read byte until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[design/a2m_seq.sv]
// Sequencer: decodes items, tracks ring pointers and fill, and drives the result register.
module a2m_seq #(
	parameter int BUF_DEPTH = a2m_pkg::BUF_DEPTH_DEF,
	parameter int IW        = $clog2(BUF_DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         s_tdata,
	input  logic [0:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,
	output logic [2:0]          m_tuser,
	output logic                m_tlast,
	output logic                wr_en,
	output logic [IW-1:0]       wr_addr,
	output logic [7:0]          wr_data,
	output logic                rd_en,
	output logic [IW-1:0]       rd_addr,
	input  logic [7:0]          rd_data
);
	import a2m_pkg::*;

	localparam int CW = $clog2(BUF_DEPTH + 1);
	localparam int LW = (CW > 6) ? CW : 6;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECIDE = 5'b00010,
		S_WRITE  = 5'b00100,
		S_READ   = 5'b01000,
		S_RESULT = 5'b10000
	} state_t;

	state_t           state_q;
	kind_t            kind_q;
	logic [5:0]       count_q;
	logic [PAT_W-1:0] pat_q;
	logic [2:0]       plen_q;
	logic             pok_q;
	status_t          res_q;
	logic [IW-1:0]    wr_idx_q;
	logic [IW-1:0]    rd_idx_q;
	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    remain_q;
	logic             pend_q;

	logic             m_valid_q;
	logic [7:0]       m_data_q;
	status_t          m_status_q;
	logic             m_last_q;

	pat_t             pat_in;
	logic             accept;
	logic             out_free;
	logic             load_out;
	logic             issue;
	logic [CW-1:0]    span;
	logic [CW-1:0]    rd_len;
	logic [CW-1:0]    room;
	logic [IW-1:0]    wr_idx_nxt;
	logic [IW-1:0]    rd_idx_nxt;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign pat_in   = pat_lookup(s_tdata[7:0]);
	assign out_free = !m_valid_q || m_tready;

	assign wr_idx_nxt = (wr_idx_q == IW'(BUF_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
	assign rd_idx_nxt = (rd_idx_q == IW'(BUF_DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;

	// run available without crossing the physical end of the array
	assign span   = (wr_idx_q > rd_idx_q) ? CW'(wr_idx_q - rd_idx_q)
	                                      : CW'(BUF_DEPTH) - CW'(rd_idx_q);
	assign rd_len = (LW'(count_q) < LW'(span)) ? CW'(count_q) : span;
	assign room   = CW'(BUF_DEPTH) - fill_q;

	assign load_out = (state_q == S_READ) && pend_q && out_free;
	assign issue    = (state_q == S_READ) && (remain_q != '0) && (!pend_q || load_out);

	assign wr_en   = (state_q == S_WRITE);
	assign wr_addr = wr_idx_q;
	assign wr_data = pat_q[PAT_W-1 -: 8];
	assign rd_en   = issue;
	assign rd_addr = rd_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			fill_q   <= '0;
			remain_q <= '0;
			pend_q   <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (kind_q == KIND_WRITE) begin
						state_q <= (pok_q && LW'(room) >= LW'(plen_q)) ? S_WRITE : S_RESULT;
					end else if (fill_q == '0 || count_q == '0) begin
						state_q <= S_RESULT;
					end else begin
						remain_q <= rd_len;
						fill_q   <= fill_q - rd_len;
						state_q  <= S_READ;
					end
				end
				S_WRITE: begin
					wr_idx_q <= wr_idx_nxt;
					fill_q   <= fill_q + 1'b1;
					if (plen_q == 3'd1) begin
						state_q <= S_RESULT;
					end
				end
				S_READ: begin
					if (issue) begin
						rd_idx_q <= rd_idx_nxt;
						remain_q <= remain_q - 1'b1;
					end
					pend_q <= issue || (pend_q && !load_out);
					if (load_out && remain_q == '0) begin
						state_q <= S_IDLE;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item and pattern payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= kind_t'(s_tuser[0]);
			count_q <= s_tdata[13:8];
			pat_q   <= pat_in.text;
			plen_q  <= pat_in.len;
			pok_q   <= pat_in.ok;
		end else if (state_q == S_WRITE) begin
			pat_q  <= pat_q << 8;
			plen_q <= plen_q - 1'b1;
		end
		if (state_q == S_DECIDE) begin
			if (kind_q == KIND_WRITE) begin
				res_q <= !pok_q ? ST_SKIP : (LW'(room) < LW'(plen_q)) ? ST_NOROOM : ST_ACCEPT;
			end else begin
				res_q <= ST_EMPTY;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out || (state_q == S_RESULT && out_free)) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_data_q   <= rd_data;
			m_status_q <= ST_BYTE;
			m_last_q   <= (remain_q == '0);
		end else if (state_q == S_RESULT && out_free) begin
			m_data_q   <= 8'd0;
			m_status_q <= res_q;
			m_last_q   <= 1'b1;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_status_q;
	assign m_tlast  = m_last_q;

`ifndef ASSERT_OFF
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(fill_q) <= LW'(BUF_DEPTH))
		else $error("fill level above ring depth");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (!pend_q && remain_q == '0))
		else $error("read still in flight while idle");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && (fill_q == '0 || LW'(fill_q) == LW'(BUF_DEPTH)))
		|-> (wr_idx_q == rd_idx_q))
		else $error("pointers disagree with empty or full ring");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && remain_q == '0) |=> (state_q == S_IDLE && m_tvalid && m_tlast))
		else $error("final read byte did not close the item");
`endif

endmodule

[design/ascii_to_morse_ring_buffer_core.sv]
// Top level: ASCII-to-Morse encoder appending into a byte ring with stream in/out.
//
// channel | dir | tdata                                   | tuser          | tlast
// s_*     | in  | [7:0] char_in, [13:8] read_count         | [0] kind       | -
// m_*     | out | [7:0] data_byte                          | [2:0] status   | last
//
// A write item is checked in S_DECIDE, then stores one pattern byte (2..7) per
// cycle in S_WRITE, then posts its result from S_RESULT.
// A read item is set up in S_DECIDE and goes through the registered ring read port,
// then returns one byte per cycle while m_tready is high, ending with the byte marked last.
// Reset clears the pointers, fill level and sequencer; ring contents are not cleared.
// While m_tready is low the result register holds and the sequencer waits for it.
module ascii_to_morse_ring_buffer_core #(
	parameter int BUF_DEPTH = a2m_pkg::BUF_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] char_in, [13:8] read_count, [15:14] zero
	input  logic [0:0]  s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] data_byte
	output logic [2:0]  m_tuser,   // [2:0] status
	output logic        m_tlast
);
	import a2m_pkg::*;

	localparam int IW = $clog2(BUF_DEPTH);

	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic [7:0]    rd_data;

	a2m_seq #(
		.BUF_DEPTH (BUF_DEPTH),
		.IW        (IW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data)
	);

	a2m_ring #(
		.DEPTH (BUF_DEPTH),
		.AW    (IW)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

[test/ascii_to_morse_ring_buffer_core_tb.sv]
// Testbench for the ASCII-to-Morse ring buffer core: directed and random items checked against a predictor.
module ascii_to_morse_ring_buffer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import a2m_pkg::*;

	localparam int RING_DEPTH = a2m_pkg::BUF_DEPTH_DEF;
	localparam int SETTLE_CYCLES = 20;

	typedef struct {
		status_t    status;
		logic [7:0] data_byte;
		logic       last;
	} morse_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;   // [7:0] char_in, [13:8] read_count, [15:14] zero
	logic [0:0]  s_tuser = '0;   // [0] kind
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;        // [7:0] data_byte
	logic [2:0]  m_tuser;        // [2:0] status
	logic        m_tlast;

	// predicted ring state
	logic [7:0]    ring_copy [RING_DEPTH];
	int            read_ptr = 0;
	int            write_ptr = 0;
	int            fill_count = 0;
	morse_result_t pending_results [$];

	int error_count = 0;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int rx_hold = 0;

	ascii_to_morse_ring_buffer_core #(
		.BUF_DEPTH(RING_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic string morse_code(input logic [7:0] c);
		logic [7:0] u;
		u = (c >= "a" && c <= "z") ? c - 8'd32 : c;
		case (u)
			"0": return "----- ";
			"1": return ".---- ";
			"2": return "..--- ";
			"3": return "...-- ";
			"4": return "....- ";
			"5": return "..... ";
			"6": return "-.... ";
			"7": return "--... ";
			"8": return "---.. ";
			"9": return "----. ";
			"A": return ".- ";
			"B": return "-... ";
			"C": return "-.-. ";
			"D": return "-.. ";
			"E": return ". ";
			"F": return "..-. ";
			"G": return "--. ";
			"H": return ".... ";
			"I": return ".. ";
			"J": return ".--- ";
			"K": return "-.- ";
			"L": return ".-.. ";
			"M": return "-- ";
			"N": return "-. ";
			"O": return "--- ";
			"P": return ".--. ";
			"Q": return "--.- ";
			"R": return ".-. ";
			"S": return "... ";
			"T": return "- ";
			"U": return "..- ";
			"V": return "...- ";
			"W": return ".-- ";
			"X": return "-..- ";
			"Y": return "-.-- ";
			"Z": return "--.. ";
			"\"": return ".-..-. ";
			"'": return ".----. ";
			"(": return "-.--. ";
			")": return "-.--.- ";
			"*": return "-..- ";
			"+": return ".-.-. ";
			",": return "--..-- ";
			"-": return "-....- ";
			".": return ".-.-.- ";
			"/": return "-..-. ";
			":": return "---... ";
			"=": return "-...- ";
			"?": return "..--.. ";
			"@": return ".--.-. ";
			default: return "";
		endcase
	endfunction

	function automatic void push_result(input status_t st, input logic [7:0] b, input logic lst);
		morse_result_t r;
		r.status = st;
		r.data_byte = b;
		r.last = lst;
		pending_results.push_back(r);
	endfunction

	// Advance the predicted ring by one accepted item and queue its results.
	function automatic void predict_item(input kind_t k, input logic [7:0] ch,
		input logic [5:0] cnt);
		string pat;
		int    run;
		int    n;
		if (k == KIND_WRITE) begin
			pat = morse_code(ch);
			if (pat.len() == 0) begin
				push_result(ST_SKIP, 8'd0, 1'b1);
			end else if (RING_DEPTH - fill_count < pat.len()) begin
				push_result(ST_NOROOM, 8'd0, 1'b1);
			end else begin
				for (int i = 0; i < pat.len(); i++) begin
					ring_copy[write_ptr] = pat[i];
					write_ptr = (write_ptr + 1) % RING_DEPTH;
					fill_count++;
				end
				push_result(ST_ACCEPT, 8'd0, 1'b1);
			end
		end else begin
			if (fill_count == 0 || cnt == 0) begin
				push_result(ST_EMPTY, 8'd0, 1'b1);
			end else begin
				// stop at write pointer or the physical end of the ring
				run = (write_ptr > read_ptr) ? write_ptr - read_ptr : RING_DEPTH - read_ptr;
				n = (int'(cnt) < run) ? int'(cnt) : run;
				for (int i = 0; i < n; i++)
					push_result(ST_BYTE, ring_copy[read_ptr + i], i == n - 1);
				fill_count -= n;
				read_ptr = (read_ptr + n) % RING_DEPTH;
			end
		end
	endfunction

	task automatic send_item(input kind_t k, input logic [7:0] ch, input logic [5:0] cnt);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, cnt, ch};
		s_tuser <= k;
		do @(posedge clk); while (!s_tready);
		predict_item(k, ch, cnt);
	endtask

	task automatic write_char(input logic [7:0] ch);
		send_item(KIND_WRITE, ch, 6'($urandom));
	endtask

	task automatic read_bytes(input logic [5:0] cnt);
		send_item(KIND_READ, 8'($urandom), cnt);
	endtask

	// Drop valid and hold until every queued result has arrived.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		morse_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d data_byte %0h last %0d",
					m_tuser, m_tdata, m_tlast);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (m_tuser !== exp_r.status) begin
					$error("status: expected %0d, actual %0d", exp_r.status, m_tuser);
					error_count++;
				end
				if (m_tdata !== exp_r.data_byte) begin
					$error("data_byte: expected %0h, actual %0h", exp_r.data_byte, m_tdata);
					error_count++;
				end
				if (m_tlast !== exp_r.last) begin
					$error("last: expected %0d, actual %0d", exp_r.last, m_tlast);
					error_count++;
				end
			end
		end
	end

	task automatic test_empty_reads();
		read_bytes(6'd1);
		read_bytes(6'd0);
		read_bytes(6'd63);
	endtask

	task automatic test_char_set();
		string chars;
		chars = "09AZaz\"'*/:=?@";
		for (int i = 0; i < chars.len(); i++) begin
			if (fill_count > 20)
				read_bytes(6'd63);
			write_char(chars[i]);
		end
		// unsupported bytes, including the field extremes
		write_char(8'h00);
		write_char(8'hff);
		write_char("!");
		write_char(8'h80);
	endtask

	task automatic test_full_and_wrap();
		while (fill_count != 0)
			read_bytes(6'd63);
		while (fill_count + 7 <= RING_DEPTH)
			write_char(".");
		write_char("0");
		write_char("E");
		write_char("T");
		write_char("E");
		read_bytes(6'd0);
		read_bytes(6'd10);
		write_char("@");
		read_bytes(6'd63);
		read_bytes(6'd63);
		read_bytes(6'd1);
	endtask

	task automatic test_random_mix(input int n_items);
		string      legal;
		int         pick;
		logic [5:0] cnt;
		legal = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz\"'()*+,-./:=?@";
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				write_char(legal[$urandom_range(legal.len() - 1)]);
			end else if (pick < 65) begin
				write_char(8'($urandom));
			end else begin
				pick = $urandom_range(99);
				if (pick < 70)
					cnt = 6'($urandom_range(8, 1));
				else if (pick < 90)
					cnt = 6'($urandom_range(32));
				else
					cnt = 6'($urandom_range(63));
				read_bytes(cnt);
			end
		end
	endtask

	// Hold the receiver off while writes keep coming, so the input stalls.
	task automatic test_backpressure();
		@(negedge clk);
		rx_hold <= 300;
		for (int i = 0; i < 30; i++)
			write_char("A" + 8'($urandom_range(25)));
		read_bytes(6'd32);
		read_bytes(6'd32);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		tx_idle_pct = 17;
		rx_idle_pct = 71;
		test_empty_reads();
		test_char_set();
		test_full_and_wrap();
		test_random_mix(165);
		drain_results();

		tx_idle_pct = 71;
		rx_idle_pct = 17;
		test_random_mix(165);
		drain_results();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_backpressure();
		test_random_mix(170);
		drain_results();

		if (error_count == 0 && pending_results.size() == 0)
			$display("ascii_to_morse_ring_buffer_core_tb OK");
		else
			$display("ascii_to_morse_ring_buffer_core_tb NOT OK");
		$finish;
	end

	initial begin
		#20ms;
		$display("ascii_to_morse_ring_buffer_core_tb NOT OK");
		$finish;
	end

endmodule
